/* hw/rtl/trbd_pkg.sv */
package trbd_pkg;

    // Sizing of the record layout
    localparam int MAX_FIELDS     = 16;
    localparam int DATE_BYTES     = 8;
    localparam int DATETIME_BYTES = 14;

    localparam logic [4:0] FIELD_LIMIT = 5'(MAX_FIELDS);
    localparam logic [6:0] DATE_LEN    = 7'(DATE_BYTES);
    localparam logic [6:0] DTIME_LEN   = 7'(DATETIME_BYTES);

    // Field type codes
    localparam logic [2:0] TYPE_I8    = 3'd0;
    localparam logic [2:0] TYPE_I16   = 3'd1;
    localparam logic [2:0] TYPE_I32   = 3'd2;
    localparam logic [2:0] TYPE_I64   = 3'd3;
    localparam logic [2:0] TYPE_ZSTR  = 3'd4;
    localparam logic [2:0] TYPE_LSTR  = 3'd5;
    localparam logic [2:0] TYPE_DATE  = 3'd6;
    localparam logic [2:0] TYPE_DTIME = 3'd7;

    // The implicit id field is a 4-byte integer
    localparam logic [2:0] I4 = TYPE_I32;

    // Result kinds
    localparam logic [1:0] KIND_INT  = 2'd0;
    localparam logic [1:0] KIND_TEXT = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    // Configuration register indexes
    localparam logic REG_USER_FIELD_COUNT = 1'b0;
    localparam logic REG_FIELD_TYPE_CODES = 1'b1;

    typedef struct packed {
        logic        expecting_count;
        logic [6:0]  records_left;
        logic [6:0]  record_index;
        logic [3:0]  field_index;
        logic [4:0]  byte_position;
        logic [6:0]  text_bytes_left;
        logic        length_pending;
        logic [63:0] integer_accumulator;
    } trbd_state_t;

    typedef struct packed {
        logic [6:0]  record_number;
        logic [3:0]  field_number;
        logic [1:0]  item_kind;
        logic [63:0] value;
        logic        field_done;
        logic        record_done;
        logic        block_done;
    } trbd_result_t;

    // Type of field fi; field 0 is always the id
    function automatic logic [2:0] field_type(input logic [3:0] fi, input logic [44:0] codes);
        logic [47:0] wide;
        logic [3:0]  k;
        logic [5:0]  base;
        wide = {3'b000, codes};
        k    = fi - 4'd1;
        base = {2'b00, k} * 6'd3;
        if (fi == 4'd0)
            return I4;
        return wide[base +: 3];
    endfunction

endpackage

/* hw/rtl/typed_record_block_deserializer.sv */
// Typed record block deserializer: parses one stream byte per transfer.
// A result is registered and shows in the cycle after the byte that causes it.
// Throughput: one byte per cycle while the result register is free or being drained;
// the parse state updates in a single pass. Reset (rst_n low, asynchronous): waits
// for a count byte, counters cleared, both configuration registers zero, no result pending.
module typed_record_block_deserializer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_enable,
    input  logic               cfg_index,
    input  logic [44:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         data_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [6:0]         record_number,
    output logic [3:0]         field_number,
    output logic [1:0]         item_kind,
    output logic signed [63:0] value,
    output logic               field_done,
    output logic               record_done,
    output logic               block_done
);
    import trbd_pkg::*;

    logic [3:0]   user_field_count_reg;
    logic [44:0]  field_type_codes_reg;
    trbd_state_t  state_reg;
    trbd_state_t  state_next;
    trbd_result_t result_reg;
    trbd_result_t result_next;
    logic         emit;
    logic         out_valid_reg;
    logic         in_fire;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            user_field_count_reg <= 4'd0;
            field_type_codes_reg <= 45'd0;
        end
        else if (cfg_write_enable)
        begin
            unique case (cfg_index)
                REG_USER_FIELD_COUNT: user_field_count_reg <= cfg_data[3:0];
                REG_FIELD_TYPE_CODES: field_type_codes_reg <= cfg_data;
            endcase
        end
    end

    trbd_parse u_parse (
        .cur              (state_reg),
        .data_byte        (data_byte),
        .user_field_count (user_field_count_reg),
        .field_type_codes (field_type_codes_reg),
        .nxt              (state_next),
        .emit             (emit),
        .res              (result_next)
    );

    // Accept whenever the result register is free or being drained
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // Parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{expecting_count: 1'b1, default: '0};
        end
        else if (in_fire)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= emit;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && emit)
            result_reg <= result_next;
    end

    assign out_valid     = out_valid_reg;
    assign record_number = result_reg.record_number;
    assign field_number  = result_reg.field_number;
    assign item_kind     = result_reg.item_kind;
    assign value         = signed'(result_reg.value);
    assign field_done    = result_reg.field_done;
    assign record_done   = result_reg.record_done;
    assign block_done    = result_reg.block_done;

    // Checks
    a_block_ends_record: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && block_done |-> record_done && field_done)
        else $error("block end without record end");

    a_record_ends_field: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && record_done |-> field_done)
        else $error("record end without field end");

    a_end_marker_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && item_kind == KIND_END |-> field_done && value == 64'sd0)
        else $error("field end marker malformed");

    a_text_byte_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && item_kind == KIND_TEXT |-> value[63:8] == 56'd0)
        else $error("text byte out of range");

endmodule

/* hw/rtl/trbd_parse.sv */
module trbd_parse (
    input  trbd_pkg::trbd_state_t  cur,
    input  logic [7:0]             data_byte,
    input  logic [3:0]             user_field_count,
    input  logic [44:0]            field_type_codes,
    output trbd_pkg::trbd_state_t  nxt,
    output logic                   emit,
    output trbd_pkg::trbd_result_t res
);
    import trbd_pkg::*;

    logic [2:0]  cur_type;
    logic [2:0]  new_type;
    logic [3:0]  new_field;
    logic [4:0]  total;
    logic        last_field;
    logic [4:0]  size_bytes;
    logic [4:0]  bp_inc;
    logic [63:0] merged;
    logic [63:0] ext_mask;
    logic        sign_bit;
    logic        fdone;

    assign cur_type = field_type(cur.field_index, field_type_codes);

    // Integer byte merge and sign extension
    assign size_bytes = 5'd1 << cur_type[1:0];
    assign bp_inc     = cur.byte_position + 5'd1;
    assign merged     = cur.integer_accumulator
                      | (64'(data_byte) << {cur.byte_position[2:0], 3'b000});

    always_comb
    begin
        case (cur_type[1:0])
            2'd0:    begin sign_bit = merged[7];  ext_mask = ~64'h0000_0000_0000_00FF; end
            2'd1:    begin sign_bit = merged[15]; ext_mask = ~64'h0000_0000_0000_FFFF; end
            2'd2:    begin sign_bit = merged[31]; ext_mask = ~64'h0000_0000_FFFF_FFFF; end
            default: begin sign_bit = 1'b0;       ext_mask = 64'h0; end
        endcase
    end

    // Field and record limits
    assign total      = ((5'd1 + {1'b0, user_field_count}) > FIELD_LIMIT)
                      ? FIELD_LIMIT : (5'd1 + {1'b0, user_field_count});
    assign last_field = ({1'b0, cur.field_index} + 5'd1) >= total;
    assign new_field  = last_field ? 4'd0 : cur.field_index + 4'd1;
    assign new_type   = field_type(cur.expecting_count ? 4'd0 : new_field, field_type_codes);

    // Per-byte step
    always_comb
    begin
        nxt   = cur;
        emit  = 1'b0;
        fdone = 1'b0;
        res.record_number = cur.record_index;
        res.field_number  = cur.field_index;
        res.item_kind     = KIND_INT;
        res.value         = 64'h0;
        res.field_done    = 1'b0;
        res.record_done   = 1'b0;
        res.block_done    = 1'b0;

        if (cur.expecting_count)
        begin
            if (data_byte != 8'd0 && !data_byte[7])
            begin
                nxt.records_left    = data_byte[6:0];
                nxt.record_index    = 7'd0;
                nxt.field_index     = 4'd0;
                nxt.expecting_count = 1'b0;
                fdone               = 1'b1;  // start field 0 below, no result
            end
        end
        else if (cur_type <= TYPE_I64)
        begin
            nxt.integer_accumulator = merged;
            nxt.byte_position       = bp_inc;
            if (!(bp_inc < size_bytes && bp_inc != 5'd0))
            begin
                emit          = 1'b1;
                fdone         = 1'b1;
                res.item_kind = KIND_INT;
                res.value     = merged | (sign_bit ? ext_mask : 64'h0);
            end
        end
        else if (cur_type == TYPE_ZSTR)
        begin
            emit = 1'b1;
            if (data_byte == 8'd0)
            begin
                res.item_kind = KIND_END;
                fdone         = 1'b1;
            end
            else
            begin
                res.item_kind = KIND_TEXT;
                res.value     = 64'(data_byte);
            end
        end
        else if (cur_type == TYPE_LSTR && cur.length_pending)
        begin
            nxt.length_pending = 1'b0;
            if (data_byte != 8'd0 && !data_byte[7])
            begin
                nxt.text_bytes_left = data_byte[6:0];
            end
            else
            begin
                emit          = 1'b1;
                fdone         = 1'b1;
                res.item_kind = KIND_END;
            end
        end
        else
        begin
            emit          = 1'b1;
            res.item_kind = KIND_TEXT;
            res.value     = 64'(data_byte);
            if (cur.text_bytes_left <= 7'd1)
            begin
                nxt.text_bytes_left = 7'd0;
                fdone               = 1'b1;
            end
            else
            begin
                nxt.text_bytes_left = cur.text_bytes_left - 7'd1;
            end
        end

        // Field, record and block completion
        if (emit && fdone)
        begin
            res.field_done = 1'b1;
            if (last_field)
            begin
                res.record_done  = 1'b1;
                nxt.field_index  = 4'd0;
                nxt.record_index = cur.record_index + 7'd1;
                if (cur.records_left <= 7'd1)
                begin
                    nxt.records_left    = 7'd0;
                    res.block_done      = 1'b1;
                    nxt.expecting_count = 1'b1;
                end
                else
                begin
                    nxt.records_left = cur.records_left - 7'd1;
                end
            end
            else
            begin
                nxt.field_index = new_field;
            end
        end

        // Start of the next field
        if (fdone)
        begin
            nxt.byte_position       = 5'd0;
            nxt.integer_accumulator = 64'h0;
            nxt.length_pending      = (new_type == TYPE_LSTR);
            if (new_type == TYPE_DATE)
                nxt.text_bytes_left = DATE_LEN;
            else if (new_type == TYPE_DTIME)
                nxt.text_bytes_left = DTIME_LEN;
            else
                nxt.text_bytes_left = 7'd0;
        end
    end

endmodule

/* test/tb_typed_record_block_deserializer.sv */
module tb_typed_record_block_deserializer;
    timeunit 1ns;
    timeprecision 1ps;

    import trbd_pkg::*;

    localparam int RANDOM_ITEMS     = 1950;
    localparam int SETTLE_CYCLES    = 2;
    localparam int DRAIN_CYCLES     = 8;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT      = 600000;

    // DUT ports
    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_write_enable;
    logic               cfg_index;
    logic [44:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [7:0]         data_byte;
    logic               out_valid;
    logic               out_ready;
    logic [6:0]         record_number;
    logic [3:0]         field_number;
    logic [1:0]         item_kind;
    logic signed [63:0] value;
    logic               field_done;
    logic               record_done;
    logic               block_done;

    typed_record_block_deserializer dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .data_byte        (data_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .record_number    (record_number),
        .field_number     (field_number),
        .item_kind        (item_kind),
        .value            (value),
        .field_done       (field_done),
        .record_done      (record_done),
        .block_done       (block_done)
    );

    always #10 clk = ~clk;

    // Directed script: a row is a register write or one byte, with its
    // result typed in where it is obvious
    typedef struct {
        bit           is_cfg;
        logic         cfg_idx;
        logic [44:0]  cfg_val;
        logic [7:0]   data;
        bit           typed;
        bit           has;
        trbd_result_t res;
    } script_row_t;

    script_row_t  script_rows[$];
    trbd_result_t pending_results[$];
    trbd_result_t head_result;

    // Parser model state and its copy of the registers
    logic [3:0]  field_count_cfg = '0;
    logic [44:0] type_codes_cfg  = '0;
    bit          awaiting_count  = 1'b1;
    logic [6:0]  records_to_go   = '0;
    logic [6:0]  cur_record      = '0;
    logic [3:0]  cur_field       = '0;
    logic [4:0]  int_byte_pos    = '0;
    logic [6:0]  text_to_go      = '0;
    bit          length_wait     = 1'b0;
    logic [63:0] int_acc         = '0;

    int fail_count   = 0;
    int cycle_count  = 0;
    int snd_calm     = 0;
    int rcv_calm     = 0;
    bit hold_request = 1'b0;

    function automatic logic [2:0] field_type_of(input logic [3:0] f);
        if (f == 4'd0)
            return I4;
        return 3'(type_codes_cfg >> (3 * (int'(f) - 1)));
    endfunction

    // Clear per-field counters when a field starts
    task automatic open_field();
        logic [2:0] t;
        t            = field_type_of(cur_field);
        int_byte_pos = '0;
        int_acc      = '0;
        length_wait  = (t == TYPE_LSTR);
        if (t == TYPE_DATE)
            text_to_go = DATE_LEN;
        else if (t == TYPE_DTIME)
            text_to_go = DTIME_LEN;
        else
            text_to_go = '0;
    endtask

    // Advance the parser model by one byte; got is set when a result is due
    task automatic parse_byte(input logic [7:0] b, output bit got, output trbd_result_t r);
        logic [2:0]  t;
        int          size;
        logic [63:0] v;
        logic [1:0]  kind;
        bit          fd;
        bit          rd;
        bit          bd;
        got  = 1'b0;
        r    = '0;
        v    = '0;
        kind = KIND_INT;
        fd   = 1'b0;
        rd   = 1'b0;
        bd   = 1'b0;
        // count byte: zero or top bit set is an empty block
        if (awaiting_count)
        begin
            if (b != 8'd0 && !b[7])
            begin
                records_to_go  = b[6:0];
                cur_record     = '0;
                cur_field      = '0;
                awaiting_count = 1'b0;
                open_field();
            end
            return;
        end
        t = field_type_of(cur_field);
        if (t <= TYPE_I64)
        begin
            // little-endian integer, done once its size is reached or passed
            size         = 1 << t;
            int_acc      = int_acc | (64'(b) << (8 * int'(int_byte_pos[2:0])));
            int_byte_pos = int_byte_pos + 5'd1;
            if (int_byte_pos < size && int_byte_pos != 5'd0)
                return;
            v = int_acc;
            if (size < 8 && v[8 * size - 1])
                v = v | ~((64'd1 << (8 * size)) - 64'd1);
            fd = 1'b1;
        end
        else if (t == TYPE_ZSTR)
        begin
            if (b == 8'd0)
            begin
                kind = KIND_END;
                fd   = 1'b1;
            end
            else
            begin
                kind = KIND_TEXT;
                v    = 64'(b);
            end
        end
        else if (t == TYPE_LSTR && length_wait)
        begin
            // length byte; zero or top bit set closes the field at once
            length_wait = 1'b0;
            if (b != 8'd0 && !b[7])
            begin
                text_to_go = b[6:0];
                return;
            end
            kind = KIND_END;
            fd   = 1'b1;
        end
        else
        begin
            kind = KIND_TEXT;
            v    = 64'(b);
            if (text_to_go <= 7'd1)
            begin
                text_to_go = '0;
                fd         = 1'b1;
            end
            else
            begin
                text_to_go = text_to_go - 7'd1;
            end
        end
        r.record_number = cur_record;
        r.field_number  = cur_field;
        r.item_kind     = kind;
        r.value         = v;
        // field, record and block bookkeeping
        if (fd)
        begin
            if (int'(cur_field) + 1 >= int'(field_count_cfg) + 1)
            begin
                rd         = 1'b1;
                cur_field  = '0;
                cur_record = cur_record + 7'd1;
                if (records_to_go <= 7'd1)
                begin
                    records_to_go  = '0;
                    bd             = 1'b1;
                    awaiting_count = 1'b1;
                end
                else
                begin
                    records_to_go = records_to_go - 7'd1;
                end
            end
            else
            begin
                cur_field = cur_field + 4'd1;
            end
            open_field();
        end
        r.field_done  = fd;
        r.record_done = rd;
        r.block_done  = bd;
        got           = 1'b1;
    endtask

    // Mostly short gaps, some long, and calm stretches with none
    task automatic pick_gap(inout int calm, output int gap);
        int r;
        if (calm > 0)
        begin
            calm--;
            gap = 0;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
            begin
                calm = $urandom_range(30, 150);
                gap  = 0;
            end
            else if (r < 55)
            begin
                gap = 0;
            end
            else if (r < 90)
            begin
                gap = $urandom_range(1, 3);
            end
            else
            begin
                gap = $urandom_range(6, 40);
            end
        end
    endtask

    function automatic logic [7:0] edge_or_random();
        if ($urandom_range(0, 4) != 0)
            return 8'($urandom);
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            default: return 8'h7F;
        endcase
    endfunction

    // Pick the next stream byte from where the parser stands: mostly
    // well-formed blocks with random content, some noise
    function automatic logic [7:0] next_stream_byte();
        logic [2:0] t;
        int         r;
        if ($urandom_range(0, 99) < 4)
            return 8'($urandom);
        if (awaiting_count)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
                return 8'h00;
            if (r < 14)
                return 8'h80 | 8'($urandom);
            if (field_count_cfg == 4'd0 && r < 16)
                return 8'd127;
            if (field_count_cfg > 4'd6)
                return 8'($urandom_range(1, 2));
            return 8'($urandom_range(1, 4));
        end
        t = field_type_of(cur_field);
        if (t == TYPE_ZSTR)
            return ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
        if (t == TYPE_LSTR && length_wait)
        begin
            r = $urandom_range(0, 99);
            if (r < 12)
                return 8'h00;
            if (r < 22)
                return 8'h80 | 8'($urandom);
            if (r < 25)
                return 8'($urandom_range(7, 127));
            return 8'($urandom_range(1, 6));
        end
        return edge_or_random();
    endfunction

    // Offer one byte and hold it until the transfer, then update the model
    task automatic feed_byte(input logic [7:0] b, output bit got, output trbd_result_t r);
        int gap;
        pick_gap(snd_calm, gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        parse_byte(b, got, r);
    endtask

    // Register write once every result is out and the pipeline has settled
    task automatic write_reg(input logic idx, input logic [44:0] val);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write_enable <= 1'b1;
        cfg_index        <= idx;
        cfg_data         <= val;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
        if (idx == REG_USER_FIELD_COUNT)
            field_count_cfg = val[3:0];
        else
            type_codes_cfg = val;
    endtask

    task automatic row_cfg(input logic idx, input logic [44:0] val);
        script_row_t row;
        row.is_cfg  = 1'b1;
        row.cfg_idx = idx;
        row.cfg_val = val;
        row.data    = '0;
        row.typed   = 1'b0;
        row.has     = 1'b0;
        row.res     = '0;
        script_rows.push_back(row);
    endtask

    task automatic row_byte(input logic [7:0] b, input bit typed);
        script_row_t row;
        row.is_cfg  = 1'b0;
        row.cfg_idx = REG_USER_FIELD_COUNT;
        row.cfg_val = '0;
        row.data    = b;
        row.typed   = typed;
        row.has     = 1'b0;
        row.res     = '0;
        script_rows.push_back(row);
    endtask

    task automatic row_result(input logic [7:0] b, input logic [6:0] rec,
                              input logic [3:0] fld, input logic [1:0] kind,
                              input logic [63:0] v, input bit fd, input bit rd,
                              input bit bd);
        script_row_t row;
        row.is_cfg            = 1'b0;
        row.cfg_idx           = REG_USER_FIELD_COUNT;
        row.cfg_val           = '0;
        row.data              = b;
        row.typed             = 1'b1;
        row.has               = 1'b1;
        row.res.record_number = rec;
        row.res.field_number  = fld;
        row.res.item_kind     = kind;
        row.res.value         = v;
        row.res.field_done    = fd;
        row.res.record_done   = rd;
        row.res.block_done    = bd;
        script_rows.push_back(row);
    endtask

    task automatic report_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // Result checker: every output transfer against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected result: expected none, actual record %0d field %0d",
                         $time, record_number, field_number);
            end
            else
            begin
                head_result = pending_results.pop_front();
                report_field("record_number", 64'(head_result.record_number),
                             64'(record_number));
                report_field("field_number", 64'(head_result.field_number),
                             64'(field_number));
                report_field("item_kind", 64'(head_result.item_kind), 64'(item_kind));
                report_field("value", head_result.value, value);
                report_field("field_done", 64'(head_result.field_done), 64'(field_done));
                report_field("record_done", 64'(head_result.record_done),
                             64'(record_done));
                report_field("block_done", 64'(head_result.block_done), 64'(block_done));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("typed_record_block_deserializer verification failed");
            $finish;
        end
    end

    // Result side: random stalls plus one long hold-off on request
    initial
    begin
        int gap;
        int burst;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= 1'b1;
            burst = $urandom_range(1, 12);
            repeat (burst) @(posedge clk);
            pick_gap(rcv_calm, gap);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // Stimulus
    initial
    begin
        bit           got;
        trbd_result_t predicted;
        logic [7:0]   b;
        logic [3:0]   nf;
        logic [44:0]  codes;
        int           phase;
        int           phase_len;
        int           sel;
        int           random_items;

        rst_n            <= 1'b0;
        cfg_write_enable <= 1'b0;
        cfg_index        <= REG_USER_FIELD_COUNT;
        cfg_data         <= '0;
        in_valid         <= 1'b0;
        data_byte        <= '0;

        // id-only records: empty blocks, then the most negative id
        row_cfg(REG_USER_FIELD_COUNT, 45'd0);
        row_cfg(REG_FIELD_TYPE_CODES, 45'd0);
        row_byte(8'h00, 1'b1);
        row_byte(8'h80, 1'b1);
        row_byte(8'h01, 1'b1);
        row_byte(8'h00, 1'b0);
        row_byte(8'h00, 1'b0);
        row_byte(8'h00, 1'b0);
        row_result(8'h80, 7'd0, 4'd0, KIND_INT, 64'hFFFF_FFFF_8000_0000, 1'b1, 1'b1, 1'b1);

        // id, i8, zero-terminated text, two length-prefixed texts
        row_cfg(REG_USER_FIELD_COUNT, 45'd4);
        row_cfg(REG_FIELD_TYPE_CODES, {33'd0, TYPE_LSTR, TYPE_LSTR, TYPE_ZSTR, TYPE_I8});
        row_byte(8'h01, 1'b1);
        row_byte(8'h01, 1'b0);
        row_byte(8'h00, 1'b0);
        row_byte(8'h00, 1'b0);
        row_result(8'h00, 7'd0, 4'd0, KIND_INT, 64'd1, 1'b1, 1'b0, 1'b0);
        row_result(8'h80, 7'd0, 4'd1, KIND_INT, 64'hFFFF_FFFF_FFFF_FF80, 1'b1, 1'b0, 1'b0);
        row_result(8'h41, 7'd0, 4'd2, KIND_TEXT, 64'h41, 1'b0, 1'b0, 1'b0);
        row_result(8'h00, 7'd0, 4'd2, KIND_END, 64'd0, 1'b1, 1'b0, 1'b0);
        // length with top bit set ends the field empty
        row_result(8'h85, 7'd0, 4'd3, KIND_END, 64'd0, 1'b1, 1'b0, 1'b0);
        row_byte(8'h02, 1'b1);
        row_result(8'hFF, 7'd0, 4'd4, KIND_TEXT, 64'hFF, 1'b0, 1'b0, 1'b0);
        row_result(8'h00, 7'd0, 4'd4, KIND_TEXT, 64'h00, 1'b1, 1'b1, 1'b1);

        // widest layout: 15 datetime fields, largest count, largest id
        row_cfg(REG_USER_FIELD_COUNT, 45'd15);
        row_cfg(REG_FIELD_TYPE_CODES, {45{1'b1}});
        row_byte(8'h7F, 1'b1);
        row_byte(8'hFF, 1'b0);
        row_byte(8'hFF, 1'b0);
        row_byte(8'hFF, 1'b0);
        row_result(8'h7F, 7'd0, 4'd0, KIND_INT, 64'h7FFF_FFFF, 1'b1, 1'b0, 1'b0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed script
        foreach (script_rows[i])
        begin
            if (script_rows[i].is_cfg)
            begin
                write_reg(script_rows[i].cfg_idx, script_rows[i].cfg_val);
            end
            else
            begin
                feed_byte(script_rows[i].data, got, predicted);
                if (script_rows[i].typed)
                begin
                    if (script_rows[i].has)
                        pending_results.push_back(script_rows[i].res);
                end
                else if (got)
                begin
                    pending_results.push_back(predicted);
                end
            end
        end

        // Random phases; each new layout lands wherever the parser stands
        phase        = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            phase++;
            sel = $urandom_range(0, 99);
            if (sel < 10)
                nf = 4'd0;
            else if (sel < 20)
                nf = 4'd15;
            else
                nf = 4'($urandom_range(0, 15));
            sel = $urandom_range(0, 99);
            if (sel < 10)
                codes = '0;
            else if (sel < 20)
                codes = {45{1'b1}};
            else
                codes = 45'({$urandom, $urandom});
            sel = $urandom_range(0, 3);
            if (sel != 1)
                write_reg(REG_USER_FIELD_COUNT, {41'd0, nf});
            if (sel != 0)
                write_reg(REG_FIELD_TYPE_CODES, codes);
            if (phase == 3)
                hold_request = 1'b1;
            phase_len = $urandom_range(40, 250);
            for (int k = 0; k < phase_len && random_items < RANDOM_ITEMS; k++)
            begin
                b = next_stream_byte();
                if (!(awaiting_count && (b == 8'd0 || b[7])))
                    random_items++;
                feed_byte(b, got, predicted);
                if (got)
                    pending_results.push_back(predicted);
            end
        end

        // Drain and let any stray result show up
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("typed_record_block_deserializer verification clean");
        else
            $display("typed_record_block_deserializer verification failed");
        $finish;
    end

endmodule
